// ===== sv/lpr_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
// Depends on nothing; used by lpr_frame_mem, lpr_scan and lru_page_replacement.
package lpr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 8;
  localparam int STAMP_W        = 32;
  localparam int CFG_W          = 5;
  localparam int FRAME_OUT_W    = 4;
  localparam int EVICT_W        = 8;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame;
    logic [EVICT_W-1:0]     evicted_page;
  } result_t;

endpackage

// ===== sv/lpr_frame_mem.sv =====
// Frame table memory: page number and use stamp per frame, one read and one write port.
// Entries read as zero until first written (per-entry valid flops). Uses lpr_pkg.
module lpr_frame_mem #(
  parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF,
  localparam int AW        = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [PAGE_BITS-1:0]       rd_page,
  output logic [lpr_pkg::STAMP_W-1:0] rd_stamp,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [PAGE_BITS-1:0]       wr_page,
  input  logic [lpr_pkg::STAMP_W-1:0] wr_stamp
);

  localparam int DW = PAGE_BITS + lpr_pkg::STAMP_W;

  logic [DW-1:0]         mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] vld_r;
  logic [DW-1:0]         q_r;
  logic                  q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_page, wr_stamp};
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written frames are empty with stamp zero
  assign rd_page  = q_vld_r ? q_r[DW-1:lpr_pkg::STAMP_W] : '0;
  assign rd_stamp = q_vld_r ? q_r[lpr_pkg::STAMP_W-1:0] : '0;

endmodule

// ===== sv/lpr_scan.sv =====
// Request sequencer: walks the active frames one per cycle, finds a hit or the LRU victim,
// then writes the frame back and forms the result word. Page zero skips walk and write. Uses lpr_pkg.
module lpr_scan #(
  parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF,
  localparam int AW        = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int CW        = $clog2(MAX_FRAMES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [PAGE_BITS-1:0]        in_page,
  input  logic [CW-1:0]               n_active,
  output logic                        busy,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [PAGE_BITS-1:0]        rd_page,
  input  logic [lpr_pkg::STAMP_W-1:0] rd_stamp,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [PAGE_BITS-1:0]        wr_page,
  output logic [lpr_pkg::STAMP_W-1:0] wr_stamp,
  output logic                        res_valid,
  output lpr_pkg::result_t            res
);

  lpr_pkg::state_t state_r, state_nxt;

  logic [PAGE_BITS-1:0]        page_r;
  logic                        zero_r;
  logic [CW-1:0]               n_r;
  logic [CW-1:0]               rd_cnt_r;
  logic                        cmp_vld_r;
  logic [AW-1:0]               cmp_idx_r;
  logic [lpr_pkg::STAMP_W-1:0] min_stamp_r;
  logic [AW-1:0]               victim_r;
  logic [PAGE_BITS-1:0]        victim_page_r;
  logic                        hit_r;
  logic [AW-1:0]               hit_idx_r;
  logic [lpr_pkg::STAMP_W-1:0] stamp_r;
  logic                        res_valid_r;
  lpr_pkg::result_t            res_r, res_nxt;

  logic                        match;
  logic                        older;
  logic                        cmp_last;
  logic [AW-1:0]               sel_idx;
  logic [31:0]                 sel_idx_ext;
  logic [31:0]                 victim_page_ext;

  assign match    = cmp_vld_r && (rd_page == page_r);
  assign older    = (cmp_idx_r == '0) || (rd_stamp < min_stamp_r);
  assign cmp_last = cmp_vld_r && ((CW'(cmp_idx_r) + CW'(1)) == n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpr_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_page == '0) ? lpr_pkg::ST_WRITE : lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (match || cmp_last) begin
          state_nxt = lpr_pkg::ST_WRITE;
        end
      end
      lpr_pkg::ST_WRITE: state_nxt = lpr_pkg::ST_IDLE;
      default:           state_nxt = lpr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    wr_en = 1'b0;
    case (state_r)
      lpr_pkg::ST_IDLE:  busy  = 1'b0;
      lpr_pkg::ST_SCAN:  rd_en = (rd_cnt_r < n_r);
      lpr_pkg::ST_WRITE: wr_en = !zero_r;
      default:           busy  = 1'b0;
    endcase
  end

  assign rd_addr  = rd_cnt_r[AW-1:0];
  assign sel_idx  = hit_r ? hit_idx_r : victim_r;
  assign wr_addr  = sel_idx;
  assign wr_page  = page_r;
  assign wr_stamp = stamp_r + lpr_pkg::STAMP_W'(1);

  assign sel_idx_ext     = 32'(sel_idx);
  assign victim_page_ext = 32'(victim_page_r);

  always_comb begin
    res_nxt = '0;
    if (!zero_r) begin
      res_nxt.hit   = hit_r;
      res_nxt.frame = sel_idx_ext[lpr_pkg::FRAME_OUT_W-1:0];
      if (!hit_r) begin
        res_nxt.evicted_page = victim_page_ext[lpr_pkg::EVICT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpr_pkg::ST_IDLE;
      stamp_r     <= '0;
      cmp_vld_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= (state_r == lpr_pkg::ST_WRITE);
      cmp_vld_r   <= rd_en;
      if (wr_en) begin
        stamp_r <= wr_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lpr_pkg::ST_IDLE && start) begin
      page_r   <= in_page;
      zero_r   <= (in_page == '0);
      n_r      <= n_active;
      rd_cnt_r <= '0;
      hit_r    <= 1'b0;
    end
    if (rd_en) begin
      rd_cnt_r <= rd_cnt_r + CW'(1);
    end
    if (state_r == lpr_pkg::ST_SCAN && cmp_vld_r) begin
      if (match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end else if (older) begin
        // strict compare keeps the lowest index on equal stamps
        min_stamp_r   <= rd_stamp;
        victim_r      <= cmp_idx_r;
        victim_page_r <= rd_page;
      end
    end
    cmp_idx_r <= rd_addr;
    if (state_r == lpr_pkg::ST_WRITE) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== sv/lru_page_replacement.sv =====
// LRU page replacement over a frame table. A fault scans all active frames, a hit ends the scan
// at the matching frame, and page zero skips it; out_valid is registered from the write state.
// The next request is taken in the cycle the result shows, so requests never overlap; one frame
// is read from the table memory per cycle. Results cannot be stalled. Synchronous active-low
// reset empties all frames, clears the stamp counter and sets the frame count to 16.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [PAGE_BITS-1:0]               in_page,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [lpr_pkg::FRAME_OUT_W-1:0]    out_frame,
  output logic [lpr_pkg::EVICT_W-1:0]        out_evicted_page,
  input  logic                               cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0]          cfg_frames_in_use
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  logic [lpr_pkg::CFG_W-1:0]   frames_in_use_r;
  logic [CW-1:0]               n_active;
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [PAGE_BITS-1:0]        rd_page, wr_page;
  logic [lpr_pkg::STAMP_W-1:0] rd_stamp, wr_stamp;
  lpr_pkg::result_t            res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= lpr_pkg::FRAMES_RESET;
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_frames_in_use;
    end
  end

  // clamp the count into 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use_r == '0) begin
      n_active = CW'(1);
    end else if (frames_in_use_r > MAX_FRAMES) begin
      n_active = CW'(MAX_FRAMES);
    end else begin
      n_active = CW'(frames_in_use_r);
    end
  end

  lpr_frame_mem #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_page  (rd_page),
    .rd_stamp (rd_stamp),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_page  (wr_page),
    .wr_stamp (wr_stamp)
  );

  lpr_scan #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_page   (in_page),
    .n_active  (n_active),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_page   (rd_page),
    .rd_stamp  (rd_stamp),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_page   (wr_page),
    .wr_stamp  (wr_stamp),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_hit          = res.hit;
  assign out_frame        = res.frame;
  assign out_evicted_page = res.evicted_page;

`ifndef SYNTHESIS
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a preceding busy cycle");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted request");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_evicted_page == '0)
    else $error("hit reported an evicted page");

  a_no_write_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !wr_en && !rd_en)
    else $error("table access while idle");
`endif

endmodule
